[hw/rtl/elevator_car_controller_macros.svh]
// ----------------------------------------------------------------------------
// Elevator car controller assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_CAR_CONTROLLER_MACROS_SVH
`define ELEVATOR_CAR_CONTROLLER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ECC_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecc check failed: same-cycle property");

// consequent must hold in the cycle after the antecedent
`define ECC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecc check failed: next-cycle property");

`endif

[hw/rtl/ecc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared widths, codes, reset values and types of the elevator car controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

	localparam int MAX_RIDERS = 16;
	localparam int NUM_FLOORS = 64;

	localparam int IDX_W   = (MAX_RIDERS > 1) ? $clog2(MAX_RIDERS) : 1;
	localparam int CNT_W   = 5;
	localparam int FLOOR_W = 6;
	localparam int MODE_W  = 2;
	localparam int REQ_W   = 3;
	localparam int DELTA_W = 16;
	localparam int TIMER_W = 24;
	localparam int CAP_W   = 5;
	localparam int MS16_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CNT_W-1:0]   RIDERS_MAX = CNT_W'(MAX_RIDERS);
	localparam logic [FLOOR_W-1:0] TOP_FLOOR  = FLOOR_W'(NUM_FLOORS - 1);
	localparam logic [FLOOR_W-1:0] HOME_FLOOR = FLOOR_W'(1);
	localparam logic [TIMER_W-1:0] TIMER_MAX  = {TIMER_W{1'b1}};

	localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UP      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DOWN    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd3;

	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_MODE   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RESET  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_TRAVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDLE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL       = 2'd3;

	localparam logic [CAP_W-1:0]   CAPACITY_RST    = 5'd8;
	localparam logic [MS16_W-1:0]  FLOOR_TRAVEL_RST = 16'd1000;
	localparam logic [TIMER_W-1:0] MAX_IDLE_RST    = 24'd10000;
	localparam logic [MS16_W-1:0]  DWELL_RST       = 16'd2000;

	typedef struct packed {
		logic [CAP_W-1:0]   capacity;
		logic [MS16_W-1:0]  floor_travel_ms;
		logic [TIMER_W-1:0] max_idle_ms;
		logic [MS16_W-1:0]  dwell_ms;
	} ecc_cfg_t;

endpackage

[hw/rtl/ecc_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_ifs
// Valid/ready channels of the elevator car controller: requests, results and
// register writes.
// ----------------------------------------------------------------------------
interface ecc_req_if;
	logic                         valid;
	logic                         ready;
	logic [ecc_pkg::REQ_W-1:0]    req_type;
	logic [ecc_pkg::DELTA_W-1:0]  delta_ms;
	logic [ecc_pkg::FLOOR_W-1:0]  target_floor;
	logic [ecc_pkg::MODE_W-1:0]   new_mode;

	modport source (output valid, req_type, delta_ms, target_floor, new_mode, input ready);
	modport sink (input valid, req_type, delta_ms, target_floor, new_mode, output ready);
endinterface

interface ecc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         added;
	logic [ecc_pkg::FLOOR_W-1:0]  floor_now;
	logic [ecc_pkg::CNT_W-1:0]    load;
	logic [ecc_pkg::MODE_W-1:0]   mode_now;

	modport source (output valid, added, floor_now, load, mode_now, input ready);
	modport sink (input valid, added, floor_now, load, mode_now, output ready);
endinterface

interface ecc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ecc_pkg::CFG_IDX_W-1:0]  index;
	logic [ecc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/elevator_car_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_car_controller
// Single elevator car: floor, mode, travel and idle/dwell timers, and an
// ordered rider target list held in a 16-entry RAM.
// ----------------------------------------------------------------------------
// Each request gives exactly one result beat. Requests are taken one at a time;
// a request can be accepted while the previous result still waits in the
// output register. An accepted request passes from the idle state through
// the execute state to the done state; a stopped car that resumes with riders
// aboard passes the first-target state on the way, since it reads the first
// target from the rider RAM. A remove request, or a tick on which a moving car
// completes its floor travel time, goes through the scan state instead, which
// walks the rider list through the RAM's single read port, one entry per cycle.
// The done state loads the result register only once the previous result has
// been taken, and the next request can be accepted after that. The rider RAM
// needs no clearing pass: only entries below the load are read.
// Register writes are always accepted and take effect on the next cycle.
module elevator_car_controller (
	input  logic       clk,
	input  logic       arst_n,
	ecc_req_if.sink    req,
	ecc_rsp_if.source  rsp,
	ecc_cfg_if.sink    cfg
);

	ecc_pkg::ecc_cfg_t                 regs;
	logic                              ram_we;
	logic [ecc_pkg::IDX_W-1:0]         ram_waddr;
	logic [ecc_pkg::FLOOR_W-1:0]       ram_wdata;
	logic [ecc_pkg::IDX_W-1:0]         ram_raddr;
	logic [ecc_pkg::FLOOR_W-1:0]       ram_rdata;

	ecc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ecc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ecc_ram #(
		.WIDTH (ecc_pkg::FLOOR_W),
		.DEPTH (ecc_pkg::MAX_RIDERS)
	) u_rider_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[hw/rtl/ecc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ecc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/ecc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_cfg_regs
// Configuration register file; always ready, one register per write beat.
// ----------------------------------------------------------------------------
module ecc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	ecc_cfg_if.sink           cfg,
	output ecc_pkg::ecc_cfg_t regs
);

	ecc_pkg::ecc_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.capacity        <= ecc_pkg::CAPACITY_RST;
			regs_q.floor_travel_ms <= ecc_pkg::FLOOR_TRAVEL_RST;
			regs_q.max_idle_ms     <= ecc_pkg::MAX_IDLE_RST;
			regs_q.dwell_ms        <= ecc_pkg::DWELL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ecc_pkg::CFG_CAPACITY: begin
					regs_q.capacity <= cfg.data[ecc_pkg::CAP_W-1:0];
				end
				ecc_pkg::CFG_FLOOR_TRAVEL: begin
					regs_q.floor_travel_ms <= cfg.data[ecc_pkg::MS16_W-1:0];
				end
				ecc_pkg::CFG_MAX_IDLE: begin
					regs_q.max_idle_ms <= cfg.data[ecc_pkg::TIMER_W-1:0];
				end
				ecc_pkg::CFG_DWELL: begin
					regs_q.dwell_ms <= cfg.data[ecc_pkg::MS16_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/ecc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_ctrl
// Car sequencer: timers, floor and mode, and read-modify-write walks over the
// rider target memory.
// ----------------------------------------------------------------------------
module ecc_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ecc_pkg::ecc_cfg_t              regs,
	ecc_req_if.sink                        req,
	ecc_rsp_if.source                      rsp,
	output logic                           ram_we,
	output logic [ecc_pkg::IDX_W-1:0]      ram_waddr,
	output logic [ecc_pkg::FLOOR_W-1:0]    ram_wdata,
	output logic [ecc_pkg::IDX_W-1:0]      ram_raddr,
	input  logic [ecc_pkg::FLOOR_W-1:0]    ram_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FIRST = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                     state_q;
	logic [ecc_pkg::REQ_W-1:0]      req_type_q;
	logic [ecc_pkg::DELTA_W-1:0]    delta_q;
	logic [ecc_pkg::FLOOR_W-1:0]    tgt_q;
	logic [ecc_pkg::MODE_W-1:0]     new_mode_q;

	logic [ecc_pkg::FLOOR_W-1:0]    floor_q;
	logic [ecc_pkg::MODE_W-1:0]     mode_q;
	logic [ecc_pkg::TIMER_W-1:0]    travel_q;
	logic [ecc_pkg::TIMER_W-1:0]    idle_q;
	logic [ecc_pkg::CNT_W-1:0]      count_q;
	logic                           added_q;

	logic [ecc_pkg::CNT_W-1:0]      rd_q;
	logic [ecc_pkg::CNT_W-1:0]      wr_q;
	logic                           pend_s1;
	logic                           stop_on_hit_q;
	logic [ecc_pkg::FLOOR_W-1:0]    scan_floor_q;

	logic                           out_valid_q;
	logic                           out_added_q;
	logic [ecc_pkg::FLOOR_W-1:0]    out_floor_q;
	logic [ecc_pkg::CNT_W-1:0]      out_load_q;
	logic [ecc_pkg::MODE_W-1:0]     out_mode_q;

	logic [ecc_pkg::TIMER_W:0]      travel_sum;
	logic [ecc_pkg::TIMER_W:0]      idle_sum;
	logic [ecc_pkg::TIMER_W-1:0]    travel_sat;
	logic [ecc_pkg::TIMER_W-1:0]    idle_sat;
	logic [ecc_pkg::FLOOR_W-1:0]    next_floor;
	logic                           add_ok;
	logic                           moving;
	logic                           arrive;
	logic                           keep;
	logic                           scan_issue;
	logic                           out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.added     = out_added_q;
	assign rsp.floor_now = out_floor_q;
	assign rsp.load      = out_load_q;
	assign rsp.mode_now  = out_mode_q;

	// saturating timer adds
	assign travel_sum = {1'b0, travel_q} + {{(ecc_pkg::TIMER_W + 1 - ecc_pkg::DELTA_W){1'b0}}, delta_q};
	assign idle_sum   = {1'b0, idle_q} + {{(ecc_pkg::TIMER_W + 1 - ecc_pkg::DELTA_W){1'b0}}, delta_q};
	assign travel_sat = travel_sum[ecc_pkg::TIMER_W] ? ecc_pkg::TIMER_MAX
		: travel_sum[ecc_pkg::TIMER_W-1:0];
	assign idle_sat   = idle_sum[ecc_pkg::TIMER_W] ? ecc_pkg::TIMER_MAX
		: idle_sum[ecc_pkg::TIMER_W-1:0];

	assign moving = (mode_q == ecc_pkg::MODE_UP) || (mode_q == ecc_pkg::MODE_DOWN);
	assign arrive = travel_sat >= {{(ecc_pkg::TIMER_W - ecc_pkg::MS16_W){1'b0}},
		regs.floor_travel_ms};
	assign add_ok = (count_q < regs.capacity) && (count_q < ecc_pkg::RIDERS_MAX);

	always_comb begin
		next_floor = floor_q;
		if (mode_q == ecc_pkg::MODE_UP) begin
			if (floor_q != ecc_pkg::TOP_FLOOR) begin
				next_floor = floor_q + 1'b1;
			end
		end else if (floor_q != '0) begin
			next_floor = floor_q - 1'b1;
		end
	end

	// compaction walk: read entry rd_q, in the next cycle keep it at wr_q or drop it
	assign keep       = pend_s1 && (ram_rdata != scan_floor_q);
	assign scan_issue = rd_q < count_q;
	assign out_free   = !out_valid_q || rsp.ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ecc_pkg::IDX_W-1:0];
		ram_wdata = tgt_q;
		ram_raddr = '0;
		case (state_q)
			ST_EXEC: begin
				ram_we = (req_type_q == ecc_pkg::REQ_ADD) && add_ok;
			end
			ST_SCAN: begin
				ram_raddr = rd_q[ecc_pkg::IDX_W-1:0];
				ram_we    = keep;
				ram_waddr = wr_q[ecc_pkg::IDX_W-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			delta_q    <= req.delta_ms;
			tgt_q      <= req.target_floor;
			new_mode_q <= req.new_mode;
		end
		if (state_q == ST_EXEC) begin
			scan_floor_q <= (req_type_q == ecc_pkg::REQ_REMOVE) ? tgt_q : next_floor;
		end
		if (state_q == ST_DONE && out_free) begin
			out_added_q <= added_q;
			out_floor_q <= floor_q;
			out_load_q  <= count_q;
			out_mode_q  <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			floor_q       <= ecc_pkg::HOME_FLOOR;
			mode_q        <= ecc_pkg::MODE_IDLE;
			travel_q      <= '0;
			idle_q        <= '0;
			count_q       <= '0;
			added_q       <= 1'b0;
			rd_q          <= '0;
			wr_q          <= '0;
			pend_s1       <= 1'b0;
			stop_on_hit_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						added_q <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q       <= ST_DONE;
					rd_q          <= '0;
					wr_q          <= '0;
					pend_s1       <= 1'b0;
					stop_on_hit_q <= 1'b0;
					case (req_type_q)
						ecc_pkg::REQ_TICK: begin
							if (moving) begin
								if (arrive) begin
									floor_q       <= next_floor;
									travel_q      <= '0;
									stop_on_hit_q <= 1'b1;
									state_q       <= ST_SCAN;
								end else begin
									travel_q <= travel_sat;
								end
							end else if (mode_q == ecc_pkg::MODE_IDLE) begin
								if (idle_sat >= regs.max_idle_ms
										&& floor_q != ecc_pkg::HOME_FLOOR) begin
									mode_q <= ecc_pkg::MODE_DOWN;
									idle_q <= '0;
								end else begin
									idle_q <= idle_sat;
								end
							end else begin
								if (idle_sat >= {{(ecc_pkg::TIMER_W - ecc_pkg::MS16_W){1'b0}},
										regs.dwell_ms}) begin
									idle_q <= '0;
									if (count_q != '0) begin
										// entry 0 read is in flight this cycle
										state_q <= ST_FIRST;
									end else begin
										mode_q <= ecc_pkg::MODE_IDLE;
									end
								end else begin
									idle_q <= idle_sat;
								end
							end
						end
						ecc_pkg::REQ_ADD: begin
							if (add_ok) begin
								count_q <= count_q + 1'b1;
								added_q <= 1'b1;
							end
						end
						ecc_pkg::REQ_REMOVE: begin
							state_q <= ST_SCAN;
						end
						ecc_pkg::REQ_MODE: begin
							mode_q <= new_mode_q;
							if (new_mode_q != ecc_pkg::MODE_IDLE) begin
								idle_q <= '0;
							end
						end
						ecc_pkg::REQ_RESET: begin
							floor_q <= ecc_pkg::HOME_FLOOR;
							count_q <= '0;
							mode_q  <= ecc_pkg::MODE_IDLE;
							idle_q  <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					if (keep) begin
						wr_q <= wr_q + 1'b1;
					end
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						rd_q <= rd_q + 1'b1;
					end
					if (!scan_issue && !pend_s1) begin
						count_q <= wr_q;
						if (stop_on_hit_q && wr_q != count_q) begin
							mode_q <= ecc_pkg::MODE_STOPPED;
						end
						state_q <= ST_DONE;
					end
				end
				ST_FIRST: begin
					mode_q  <= (ram_rdata > floor_q) ? ecc_pkg::MODE_UP : ecc_pkg::MODE_DOWN;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ecc_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_chk
// Port-level checks of the elevator car controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "elevator_car_controller_macros.svh"

module ecc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_added,
	input logic [ecc_pkg::FLOOR_W-1:0]   rsp_floor_now,
	input logic [ecc_pkg::CNT_W-1:0]     rsp_load,
	input logic [ecc_pkg::MODE_W-1:0]    rsp_mode_now
);

	// a stalled result beat stays put
	`ECC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`ECC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_added) && $stable(rsp_floor_now) && $stable(rsp_load) && $stable(rsp_mode_now))
	// the list never holds more riders than the RAM has entries
	`ECC_ASSERT_SAME(a_load_max, rsp_valid, rsp_load <= ecc_pkg::RIDERS_MAX)
	// an accepted add leaves at least one rider aboard
	`ECC_ASSERT_SAME(a_added_load, rsp_valid && rsp_added, rsp_load != '0)

endmodule

bind elevator_car_controller ecc_chk u_ecc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_added     (rsp.added),
	.rsp_floor_now (rsp.floor_now),
	.rsp_load      (rsp.load),
	.rsp_mode_now  (rsp.mode_now)
);

[tb/sv/tb_elevator_car_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevator_car_controller
// Self-checking bench for the elevator car controller. A request-level model of
// the car (floor, mode, timers, rider list, registers) predicts one result per
// accepted request; a monitor compares every result beat against the oldest
// prediction. Directed tests hit the edge cases, then random phases run with
// varied register settings and handshake gaps on both channels.
// ----------------------------------------------------------------------------
module tb_elevator_car_controller;
	import ecc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [REQ_W-1:0]   kind;
		logic [DELTA_W-1:0] delta_ms;
		logic [FLOOR_W-1:0] target_floor;
		logic [MODE_W-1:0]  new_mode;
	} car_req_t;

	typedef struct packed {
		logic               added;
		logic [FLOOR_W-1:0] floor_now;
		logic [CNT_W-1:0]   load;
		logic [MODE_W-1:0]  mode_now;
	} car_rsp_t;

	logic clk;
	logic arst_n;

	ecc_req_if req_ch ();
	ecc_rsp_if rsp_ch ();
	ecc_cfg_if cfg_ch ();

	elevator_car_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// car model state
	logic [FLOOR_W-1:0] car_floor;
	logic [MODE_W-1:0]  car_mode;
	logic [TIMER_W-1:0] travel_ms;
	logic [TIMER_W-1:0] idle_ms;
	logic [FLOOR_W-1:0] rider_dest [MAX_RIDERS];
	logic [CNT_W-1:0]   riders;

	// register copies
	logic [CAP_W-1:0]   cap_cfg;
	logic [MS16_W-1:0]  travel_cfg;
	logic [TIMER_W-1:0] idle_limit_cfg;
	logic [MS16_W-1:0]  dwell_cfg;

	car_rsp_t car_results_due [$];
	int       mismatches;
	int       cycles;
	int       send_idle_pct;
	int       sink_stall_pct;
	int       sink_hold;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[elevator_car_controller] ERROR");
			$finish;
		end
	end

	// ---------------- car model ----------------

	function automatic logic [TIMER_W-1:0] sat_sum(logic [TIMER_W-1:0] t, logic [DELTA_W-1:0] d);
		logic [TIMER_W:0] s;
		s = {1'b0, t} + d;
		return (s > {1'b0, TIMER_MAX}) ? TIMER_MAX : s[TIMER_W-1:0];
	endfunction

	function automatic bit rider_bound_for(logic [FLOOR_W-1:0] fl);
		for (int i = 0; i < riders && i < MAX_RIDERS; i++)
			if (rider_dest[i] == fl)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void drop_riders(logic [FLOOR_W-1:0] fl);
		int k;
		k = 0;
		for (int i = 0; i < riders && i < MAX_RIDERS; i++) begin
			if (rider_dest[i] != fl) begin
				rider_dest[k] = rider_dest[i];
				k++;
			end
		end
		riders = CNT_W'(k);
	endfunction

	function automatic void tick_car(logic [DELTA_W-1:0] d);
		if (car_mode == MODE_UP || car_mode == MODE_DOWN) begin
			travel_ms = sat_sum(travel_ms, d);
			if (travel_ms >= travel_cfg) begin
				if (car_mode == MODE_UP) begin
					if (car_floor < TOP_FLOOR)
						car_floor++;
				end else if (car_floor > 0) begin
					car_floor--;
				end
				travel_ms = '0;
				if (rider_bound_for(car_floor)) begin
					car_mode = MODE_STOPPED;
					drop_riders(car_floor);
				end
			end
		end else if (car_mode == MODE_IDLE) begin
			idle_ms = sat_sum(idle_ms, d);
			if (idle_ms >= idle_limit_cfg && car_floor != HOME_FLOOR) begin
				car_mode = MODE_DOWN;
				idle_ms = '0;
			end
		end else begin
			idle_ms = sat_sum(idle_ms, d);
			if (idle_ms >= dwell_cfg) begin
				if (riders > 0)
					car_mode = (rider_dest[0] > car_floor) ? MODE_UP : MODE_DOWN;
				else
					car_mode = MODE_IDLE;
				idle_ms = '0;
			end
		end
	endfunction

	function automatic car_rsp_t advance_car(car_req_t r);
		car_rsp_t e;
		e.added = 1'b0;
		case (r.kind)
			REQ_TICK: tick_car(r.delta_ms);
			REQ_ADD: begin
				if (riders < cap_cfg && riders < MAX_RIDERS) begin
					rider_dest[riders] = r.target_floor;
					riders++;
					e.added = 1'b1;
				end
			end
			REQ_REMOVE: drop_riders(r.target_floor);
			REQ_MODE: begin
				car_mode = r.new_mode;
				if (r.new_mode != MODE_IDLE)
					idle_ms = '0;
			end
			REQ_RESET: begin
				car_floor = HOME_FLOOR;
				riders = '0;
				car_mode = MODE_IDLE;
				idle_ms = '0;
			end
			default: ;
		endcase
		e.floor_now = car_floor;
		e.load = riders;
		e.mode_now = car_mode;
		return e;
	endfunction

	// ---------------- result checking ----------------

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		car_rsp_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (car_results_due.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				e = car_results_due.pop_front();
				check_field("added", e.added, rsp_ch.added);
				check_field("floor_now", e.floor_now, rsp_ch.floor_now);
				check_field("load", e.load, rsp_ch.load);
				check_field("mode_now", e.mode_now, rsp_ch.mode_now);
			end
		end
	end

	// result side back-pressure; sink_hold forces a long stall
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ---------------- drivers (called at the falling edge) ----------------

	task automatic send_req(car_req_t r);
		car_rsp_t due;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= r.kind;
		req_ch.delta_ms     <= r.delta_ms;
		req_ch.target_floor <= r.target_floor;
		req_ch.new_mode     <= r.new_mode;
		do @(posedge clk); while (!req_ch.ready);
		due = advance_car(r);
		car_results_due.insert(car_results_due.size(), due);
		@(negedge clk);
	endtask

	task automatic issue(logic [REQ_W-1:0] kind, logic [DELTA_W-1:0] d,
			logic [FLOOR_W-1:0] tgt, logic [MODE_W-1:0] m);
		car_req_t r;
		r.kind = kind;
		r.delta_ms = d;
		r.target_floor = tgt;
		r.new_mode = m;
		send_req(r);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (car_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_CAPACITY:     cap_cfg = v[CAP_W-1:0];
			CFG_FLOOR_TRAVEL: travel_cfg = v[MS16_W-1:0];
			CFG_MAX_IDLE:     idle_limit_cfg = v[TIMER_W-1:0];
			CFG_DWELL:        dwell_cfg = v[MS16_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// registers change only with the car drained and quiet
	task automatic set_config(int cap, int trav, int idle_lim, int dwell);
		wait_drained();
		repeat (4) @(negedge clk);
		write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
		write_reg(CFG_FLOOR_TRAVEL, CFG_DATA_W'(trav));
		write_reg(CFG_MAX_IDLE, CFG_DATA_W'(idle_lim));
		write_reg(CFG_DWELL, CFG_DATA_W'(dwell));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// ---------------- tests ----------------

	// every request kind and the basic trip cycle at reset register values
	task automatic test_basic_trip();
		issue(3'd5, 16'hFFFF, TOP_FLOOR, MODE_STOPPED);
		issue(3'd7, 16'h0000, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'd0, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'hFFFF, 6'd0, MODE_IDLE);   // idle at floor one never moves
		issue(REQ_ADD, 16'd0, 6'd0, MODE_IDLE);
		issue(REQ_ADD, 16'd0, TOP_FLOOR, MODE_IDLE);
		issue(REQ_ADD, 16'd0, 6'd2, MODE_IDLE);
		issue(REQ_ADD, 16'd0, 6'd2, MODE_IDLE);
		issue(REQ_REMOVE, 16'd0, TOP_FLOOR, MODE_IDLE);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_UP);
		issue(REQ_TICK, 16'd999, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'd1, 6'd0, MODE_IDLE);      // floor 2: stop, drop both
		issue(REQ_TICK, 16'd1999, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'd1, 6'd0, MODE_IDLE);      // resume down toward 0
		issue(REQ_TICK, 16'd1000, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'd1000, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'd2000, 6'd0, MODE_IDLE);   // empty list: go idle
		issue(REQ_MODE, 16'd0, 6'd0, MODE_DOWN);
		issue(REQ_TICK, 16'd1000, 6'd0, MODE_IDLE);   // already at floor 0
		issue(REQ_MODE, 16'd0, 6'd0, MODE_STOPPED);
		issue(REQ_ADD, 16'd0, 6'd0, MODE_IDLE);       // target equals current floor
		issue(REQ_TICK, 16'd2000, 6'd0, MODE_IDLE);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'd10000, 6'd0, MODE_IDLE);  // idle limit away from home
		issue(REQ_RESET, 16'h5A5A, 6'h2A, MODE_UP);
	endtask

	// zero/max register values, full list, floor limits
	task automatic test_register_extremes();
		set_config(0, 0, 1, 0);
		issue(REQ_ADD, 16'd0, 6'd5, MODE_IDLE);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_UP);
		issue(REQ_TICK, 16'd0, 6'd0, MODE_IDLE);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_STOPPED);
		issue(REQ_TICK, 16'd0, 6'd0, MODE_IDLE);
		issue(REQ_TICK, 16'd0, 6'd0, MODE_IDLE);
		issue(REQ_RESET, 16'd0, 6'd0, MODE_IDLE);

		set_config(31, 1, int'(TIMER_MAX), 65535);
		for (int i = 0; i < MAX_RIDERS + 1; i++)
			issue(REQ_ADD, 16'($urandom), 6'($urandom), 2'($urandom));
		issue(REQ_RESET, 16'd0, 6'd0, MODE_IDLE);

		set_config(16, 65535, int'(TIMER_MAX), 1);
		for (int i = 0; i < MAX_RIDERS + 1; i++)
			issue(REQ_ADD, 16'd0, 6'(i + 3), MODE_IDLE);
		issue(REQ_REMOVE, 16'd0, 6'd5, MODE_IDLE);
		issue(REQ_RESET, 16'd0, 6'd0, MODE_IDLE);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_UP);
		for (int i = 0; i < NUM_FLOORS + 1; i++)
			issue(REQ_TICK, 16'hFFFF, 6'd0, MODE_IDLE);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_DOWN);
		issue(REQ_TICK, 16'hFFFF, 6'd0, MODE_IDLE);
		issue(REQ_RESET, 16'd0, 6'd0, MODE_IDLE);
	endtask

	// idle timer must clamp at its maximum, not wrap
	task automatic test_idle_saturation();
		set_config(8, 1, int'(TIMER_MAX), 2000);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_UP);
		issue(REQ_TICK, 16'd1, 6'd0, MODE_IDLE);
		issue(REQ_MODE, 16'd0, 6'd0, MODE_IDLE);
		for (int i = 0; i < 257; i++)
			issue(REQ_TICK, 16'hFFFF, 6'($urandom), 2'($urandom));
		issue(REQ_RESET, 16'd0, 6'd0, MODE_IDLE);
	endtask

	function automatic car_req_t pick_req();
		car_req_t r;
		int roll, f, lim;
		r.kind = REQ_TICK;
		r.delta_ms = 16'($urandom);
		r.target_floor = 6'($urandom);
		r.new_mode = 2'($urandom);
		roll = $urandom_range(99);
		if (roll < 55) begin
			case ($urandom_range(3))
				0: ;
				1: begin
					lim = 2 * ((travel_cfg > dwell_cfg) ? travel_cfg : dwell_cfg);
					r.delta_ms = 16'($urandom_range(0, (lim > 65535) ? 65535 : lim));
				end
				2: r.delta_ms = $urandom_range(1) ? travel_cfg : dwell_cfg;
				default: r.delta_ms = 16'($urandom_range(15));
			endcase
		end else if (roll < 77) begin
			r.kind = REQ_ADD;
			if ($urandom_range(99) < 70) begin
				f = int'(car_floor) + $urandom_range(12) - 6;
				r.target_floor = FLOOR_W'((f < 0) ? 0 : (f > NUM_FLOORS - 1) ? NUM_FLOORS - 1 : f);
			end
		end else if (roll < 85) begin
			r.kind = REQ_REMOVE;
			if (riders > 0 && $urandom_range(99) < 60)
				r.target_floor = rider_dest[$urandom_range(0, riders - 1)];
		end else if (roll < 92) begin
			r.kind = REQ_MODE;
		end else if (roll < 96) begin
			r.kind = REQ_RESET;
		end else begin
			r.kind = REQ_W'($urandom_range(5, 7));
		end
		return r;
	endfunction

	task automatic test_random_traffic(int n, int idle_pct, int stall_pct, bit extremes);
		int cap;
		if (extremes) begin
			set_config($urandom_range(1) ? 0 : 31, $urandom_range(1) ? 0 : 65535,
				int'(TIMER_MAX), $urandom_range(1) ? 0 : 65535);
		end else begin
			cap = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
			set_config(cap, $urandom_range(1, 3000), $urandom_range(1, 30000),
				$urandom_range(1, 4000));
		end
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			send_req(pick_req());
	endtask

	// long result stall fills the block, then sender waits for a full drain
	task automatic test_result_backpressure();
		set_config(16, 500, 3000, 700);
		send_idle_pct = 0;
		sink_stall_pct = 0;
		sink_hold = 400;
		for (int i = 0; i < 40; i++)
			send_req(pick_req());
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_req(pick_req());
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.delta_ms = '0;
		req_ch.target_floor = '0;
		req_ch.new_mode = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		sink_hold = 0;

		car_floor = HOME_FLOOR;
		car_mode = MODE_IDLE;
		travel_ms = '0;
		idle_ms = '0;
		riders = '0;
		foreach (rider_dest[i])
			rider_dest[i] = '0;
		cap_cfg = CAPACITY_RST;
		travel_cfg = FLOOR_TRAVEL_RST;
		idle_limit_cfg = MAX_IDLE_RST;
		dwell_cfg = DWELL_RST;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_trip();
		test_register_extremes();
		test_idle_saturation();
		test_random_traffic(220, 0, 0, 1'b0);
		test_random_traffic(220, 46, 0, 1'b0);
		test_result_backpressure();
		test_random_traffic(220, 0, 46, 1'b0);
		test_random_traffic(220, 36, 36, 1'b0);
		test_random_traffic(80, 20, 20, 1'b1);

		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("[elevator_car_controller] OK");
		else
			$display("[elevator_car_controller] ERROR");
		$finish;
	end

endmodule
